FILE: design/sar_pkg.sv
// ----------------------------------------------------------------------------
// Scroll address register unit package
// Transaction types, event codes and address field masks shared by the
// scroll and address register unit.
// ----------------------------------------------------------------------------
package sar_pkg;

   localparam int unsigned ADDR_W = 15;
   localparam int unsigned FUNC_W = 4;
   localparam int unsigned DATA_W = 8;
   localparam int unsigned FINE_W = 3;

   // Event codes carried in the func field
   localparam logic [FUNC_W-1:0] FUNC_CTRL_WRITE   = 4'd0;
   localparam logic [FUNC_W-1:0] FUNC_SCROLL_WRITE = 4'd1;
   localparam logic [FUNC_W-1:0] FUNC_ADDR_WRITE   = 4'd2;
   localparam logic [FUNC_W-1:0] FUNC_STATUS_READ  = 4'd3;
   localparam logic [FUNC_W-1:0] FUNC_DATA_ACCESS  = 4'd4;
   localparam logic [FUNC_W-1:0] FUNC_HORI_INC     = 4'd5;
   localparam logic [FUNC_W-1:0] FUNC_VERT_INC     = 4'd6;
   localparam logic [FUNC_W-1:0] FUNC_HORI_COPY    = 4'd7;
   localparam logic [FUNC_W-1:0] FUNC_VERT_COPY    = 4'd8;

   // Address layout: fine Y [14:12], nametable [11:10], coarse Y [9:5], coarse X [4:0]
   localparam logic [ADDR_W-1:0] HORI_MASK     = 15'h041F;
   localparam logic [ADDR_W-1:0] FINE_Y_MASK   = 15'h7000;
   localparam logic [ADDR_W-1:0] COARSE_Y_MASK = 15'h03E0;
   localparam logic [ADDR_W-1:0] NT_V_BIT      = 15'h0800;
   localparam logic [ADDR_W-1:0] NT_H_BIT      = 15'h0400;
   localparam logic [ADDR_W-1:0] FINE_Y_STEP   = 15'h1000;
   localparam logic [ADDR_W-1:0] COL_STEP      = 15'd1;
   localparam logic [ADDR_W-1:0] ROW_STEP      = 15'd32;
   localparam logic [5:0]        ADDR_HI_MASK  = 6'h3F;
   localparam logic [4:0]        COARSE_LAST   = 5'd31;
   localparam logic [4:0]        COARSE_Y_WRAP = 5'd29;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [DATA_W-1:0] data;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] vram_addr;
      logic [ADDR_W-1:0] temp_addr;
      logic [FINE_W-1:0] fine_x;
      logic              second_write;
      logic [ADDR_W-1:0] access_addr;
   } rsp_type;

endpackage

FILE: design/scroll_address_register_unit.sv
// ----------------------------------------------------------------------------
// Scroll address register unit
// Current/temporary video address, fine X scroll and write toggle, updated
// by one processor or render event per transaction.
// ----------------------------------------------------------------------------
// Each request transaction is one event. It is captured in an input register,
// then the event logic updates the address state and loads the result register
// in the same edge once that register is empty or draining, so one event can
// enter every cycle while the response side does not stall. Back pressure on the
// response side stalls the input register, which in turn drops req_ready; the
// input register still takes a new transaction whenever the result register
// is empty or is being drained. The whole cost per event is three 15-bit
// additions, a 5-bit coarse Y increment and some field muxing.
module scroll_address_register_unit
   import sar_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_item
);

   // Input stage
   logic    in_valid_ff;
   req_type in_item_ff;

   // Address state
   logic [ADDR_W-1:0] cur_addr_ff, cur_addr_in;
   logic [ADDR_W-1:0] tmp_addr_ff, tmp_addr_in;
   logic [FINE_W-1:0] fine_x_ff, fine_x_in;
   logic              toggle_ff, toggle_in;
   logic              step_row_ff, step_row_in;
   logic [ADDR_W-1:0] access_in;

   // Result stage
   logic    rsp_valid_ff;
   rsp_type rsp_item_ff;

   logic    load_rsp;
   logic    take_req;

   logic [4:0]        coarse_y;
   logic [ADDR_W-1:0] hori_addr;
   logic [ADDR_W-1:0] vert_addr;
   logic [ADDR_W-1:0] vert_base;

   // Advance the event into the result register when it is empty or draining
   assign load_rsp  = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || load_rsp;
   assign take_req  = req_valid && req_ready;

   // Horizontal increment: wrap coarse X at 31 and flip the horizontal nametable
   always_comb begin
      if (cur_addr_ff[4:0] == COARSE_LAST) begin
         hori_addr = {cur_addr_ff[ADDR_W-1:5], 5'd0} ^ NT_H_BIT;
      end else begin
         hori_addr = cur_addr_ff + COL_STEP;
      end
   end

   // Vertical increment: fine Y first, then coarse Y with the row-29 wrap (row 31 wraps without a flip)
   always_comb begin
      vert_base = cur_addr_ff & ~FINE_Y_MASK;
      coarse_y  = cur_addr_ff[9:5];
      if ((cur_addr_ff & FINE_Y_MASK) != FINE_Y_MASK) begin
         vert_addr = cur_addr_ff + FINE_Y_STEP;
      end else if (coarse_y == COARSE_Y_WRAP) begin
         vert_addr = (vert_base & ~COARSE_Y_MASK) ^ NT_V_BIT;
      end else if (coarse_y == COARSE_LAST) begin
         vert_addr = vert_base & ~COARSE_Y_MASK;
      end else begin
         vert_addr = {vert_base[ADDR_W-1:10], coarse_y + 5'd1, vert_base[4:0]};
      end
   end

   // Event decode: next state and access address
   always_comb begin
      cur_addr_in = cur_addr_ff;
      tmp_addr_in = tmp_addr_ff;
      fine_x_in   = fine_x_ff;
      toggle_in   = toggle_ff;
      step_row_in = step_row_ff;
      access_in   = '0;
      case (in_item_ff.func)
         FUNC_CTRL_WRITE: begin
            tmp_addr_in[11:10] = in_item_ff.data[1:0];
            step_row_in        = in_item_ff.data[2];
         end
         FUNC_SCROLL_WRITE: begin
            if (!toggle_ff) begin
               fine_x_in        = in_item_ff.data[2:0];
               tmp_addr_in[4:0] = in_item_ff.data[7:3];
            end else begin
               tmp_addr_in[14:12] = in_item_ff.data[2:0];
               tmp_addr_in[9:5]   = in_item_ff.data[7:3];
            end
            toggle_in = !toggle_ff;
         end
         FUNC_ADDR_WRITE: begin
            if (!toggle_ff) begin
               tmp_addr_in = {1'b0, in_item_ff.data[5:0] & ADDR_HI_MASK, tmp_addr_ff[7:0]};
            end else begin
               tmp_addr_in = {tmp_addr_ff[ADDR_W-1:8], in_item_ff.data};
               cur_addr_in = {tmp_addr_ff[ADDR_W-1:8], in_item_ff.data};
            end
            toggle_in = !toggle_ff;
         end
         FUNC_STATUS_READ: begin
            toggle_in = 1'b0;
         end
         FUNC_DATA_ACCESS: begin
            access_in   = cur_addr_ff;
            cur_addr_in = cur_addr_ff + (step_row_ff ? ROW_STEP : COL_STEP);
         end
         FUNC_HORI_INC: begin
            cur_addr_in = hori_addr;
         end
         FUNC_VERT_INC: begin
            cur_addr_in = vert_addr;
         end
         FUNC_HORI_COPY: begin
            cur_addr_in = (cur_addr_ff & ~HORI_MASK) | (tmp_addr_ff & HORI_MASK);
         end
         FUNC_VERT_COPY: begin
            cur_addr_in = (cur_addr_ff & HORI_MASK) | (tmp_addr_ff & ~HORI_MASK);
         end
         default: begin
            // Unused codes leave the state alone
         end
      endcase
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cur_addr_ff  <= '0;
         tmp_addr_ff  <= '0;
         fine_x_ff    <= '0;
         toggle_ff    <= 1'b0;
         step_row_ff  <= 1'b0;
      end else begin
         if (take_req) begin
            in_valid_ff <= 1'b1;
         end else if (load_rsp) begin
            in_valid_ff <= 1'b0;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
            cur_addr_ff  <= cur_addr_in;
            tmp_addr_ff  <= tmp_addr_in;
            fine_x_ff    <= fine_x_in;
            toggle_ff    <= toggle_in;
            step_row_ff  <= step_row_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: hold while stalled
   always_ff @(posedge clock) begin
      if (take_req) begin
         in_item_ff <= req_item;
      end
      if (load_rsp) begin
         rsp_item_ff.vram_addr    <= cur_addr_in;
         rsp_item_ff.temp_addr    <= tmp_addr_in;
         rsp_item_ff.fine_x       <= fine_x_in;
         rsp_item_ff.second_write <= toggle_in;
         rsp_item_ff.access_addr  <= access_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef SYNTHESIS
   // A pending response always mirrors the live address state
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.vram_addr == cur_addr_ff) &&
                    (rsp_item.temp_addr == tmp_addr_ff) &&
                    (rsp_item.second_write == toggle_ff))
      else $error("response does not match address state");

   // An empty result register never blocks the request side
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty result register");

   // A status read always leaves the toggle cleared
   assert property (@(posedge clock) disable iff (reset)
      (load_rsp && (in_item_ff.func == FUNC_STATUS_READ)) |=> !toggle_ff)
      else $error("status read did not clear write toggle");

   // Only a data access reports a nonzero access address
   assert property (@(posedge clock) disable iff (reset)
      (load_rsp && (in_item_ff.func != FUNC_DATA_ACCESS)) |=> (rsp_item.access_addr == '0))
      else $error("access address set by non-access event");
`endif

endmodule
